### rtl/core/d2csr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d2csr_pkg: shared types and constants
// Register indexes, result kinds and the slot bundle between the two stages.
// ----------------------------------------------------------------------------
package d2csr_pkg;

    localparam int MaxRowsDefault = 4096;
    localparam int MaxColsDefault = 4096;
    localparam int CfgIdxW        = 2;
    localparam int CfgDataW       = 32;
    localparam int SizeW          = 13;
    localparam int ColW           = 12;
    localparam int ValW           = 32;
    localparam int PtrW           = 25;
    localparam logic [PtrW-1:0] KeptMax = '1;
    localparam int OutDataW       = 72;

    typedef enum logic [CfgIdxW-1:0] {
        REG_HALF      = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_ROWS      = 2'd2,
        REG_COLS      = 2'd3
    } reg_idx_t;

    typedef enum logic {
        KIND_ENTRY = 1'b0,
        KIND_PTR   = 1'b1
    } kind_t;

    // up to three results caused by one element
    typedef struct packed {
        logic            first_ptr;
        logic            entry;
        logic            end_ptr;
        logic            last;
        logic [ColW-1:0] column;
        logic [ValW-1:0] value;
        logic [PtrW-1:0] ptr;
    } slot_t;

endpackage

### rtl/core/dense_to_csr_stream_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_to_csr_stream_unit: dense matrix to CSR stream converter
// Keeps elements past a magnitude threshold and emits CSR entries and row
// pointers for a row-major element stream.
//
//   channel   | dir | payload
//   s_axis    | in  | tdata[31:0] element_bits
//   m_axis    | out | tdata: column_index, entry_value, row_pointer; tuser kind;
//             |     | tlast last
//   cfg       | in  | wr_en, wr_index, wr_data (0 half, 1 threshold, 2 rows,
//             |     | 3 cols)
//
// An element is accepted whenever the slot can reload; the compare and counter update sit
// between the input handshake and the result slot register. Each element
// causes zero to three result transactions, sent one per cycle while m_axis_tready is
// high, so the input runs at one element per cycle whenever an element causes at most
// one result and the output does not stall. The slot reloads in the same cycle its last
// result leaves. Reset clears counters, half and threshold, sets rows and cols to one; output stalls hold the slot.
// ----------------------------------------------------------------------------
module dense_to_csr_stream_unit
#(
    parameter int MAX_ROWS = d2csr_pkg::MaxRowsDefault,
    parameter int MAX_COLS = d2csr_pkg::MaxColsDefault
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [d2csr_pkg::CfgIdxW-1:0]     wr_index,
    input  logic [d2csr_pkg::CfgDataW-1:0]    wr_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,   // element_bits[31:0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // column_index[11:0], entry_value[43:12], row_pointer[68:44], zero pad
    output logic [d2csr_pkg::OutDataW-1:0]    m_axis_tdata,
    output logic                              m_axis_tuser,   // kind
    output logic                              m_axis_tlast
);
    import d2csr_pkg::*;

    localparam logic [SizeW-1:0] RowsMax = SizeW'(MAX_ROWS > 4096 ? 4096 : MAX_ROWS);
    localparam logic [SizeW-1:0] ColsMax = SizeW'(MAX_COLS > 4096 ? 4096 : MAX_COLS);

    logic             half_reg;
    logic [31:0]      thr_reg;
    logic [SizeW-1:0] rows_reg, cols_reg;
    logic [ColW-1:0]  col_reg, col_next, row_reg, row_next;
    logic [PtrW-1:0]  kept_reg, kept_next;
    logic [SizeW-1:0] rows_eff, cols_eff;
    logic             keep, accept, row_end, final_row, load_ok;
    slot_t            slot;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= 1'b0;
            thr_reg  <= '0;
            rows_reg <= SizeW'(1);
            cols_reg <= SizeW'(1);
        end
        else if (wr_en)
        begin
            case (reg_idx_t'(wr_index))
                REG_HALF:      half_reg <= wr_data[0];
                REG_THRESHOLD: thr_reg  <= wr_data;
                REG_ROWS:      rows_reg <= wr_data[SizeW-1:0];
                REG_COLS:      cols_reg <= wr_data[SizeW-1:0];
                default:       ;
            endcase
        end
    end

    // Clamp sizes: zero acts as one, oversize acts as the maximum
    always_comb
    begin
        rows_eff = (rows_reg == '0) ? SizeW'(1) : (rows_reg > RowsMax ? RowsMax : rows_reg);
        cols_eff = (cols_reg == '0) ? SizeW'(1) : (cols_reg > ColsMax ? ColsMax : cols_reg);
    end

    d2csr_keep u_keep
    (
        .half_precision (half_reg),
        .threshold_bits (thr_reg),
        .element_bits   (s_axis_tdata),
        .keep           (keep)
    );

    assign s_axis_tready = load_ok;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign row_end       = {1'b0, col_reg} >= cols_eff - SizeW'(1);
    assign final_row     = {1'b0, row_reg} >= rows_eff - SizeW'(1);

    // Counter update and result slot build
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        kept_next = kept_reg;
        slot.first_ptr = (col_reg == '0) && (row_reg == '0);
        slot.entry     = keep;
        slot.end_ptr   = row_end;
        slot.last      = row_end && final_row;
        slot.column    = col_reg;
        slot.value     = half_reg ? {16'd0, s_axis_tdata[15:0]} : s_axis_tdata;
        if (keep && kept_reg != KeptMax)
            kept_next = kept_reg + PtrW'(1);
        slot.ptr = kept_next;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                if (final_row)
                begin
                    row_next  = '0;
                    kept_next = '0;
                end
                else
                    row_next = row_reg + ColW'(1);
            end
            else
                col_next = col_reg + ColW'(1);
        end
        else
            kept_next = kept_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            kept_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            kept_reg <= kept_next;
        end
    end

    d2csr_serializer u_ser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .slot          (slot),
        .empty_next_ok (load_ok),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Last only on a row pointer
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_PTR)
        else $error("last on entry");
    // Matrix end returns counters to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && row_end && final_row |=> col_reg == '0 && row_reg == '0 && kept_reg == '0)
        else $error("counters not cleared");
    // Every accepted element yields at least one result next cycle when first
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && slot.first_ptr |=> m_axis_tvalid && m_axis_tuser == KIND_PTR)
        else $error("missing first pointer");

endmodule

### rtl/core/d2csr_keep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d2csr_keep: threshold compare
// Decides whether an element passes the magnitude threshold (IEEE order).
// ----------------------------------------------------------------------------
module d2csr_keep
(
    input  logic        half_precision,
    input  logic [31:0] threshold_bits,
    input  logic [31:0] element_bits,
    output logic        keep
);
    logic        v_nan, t_nan, v_neg, t_neg, v_zero, t_zero;
    logic [30:0] v_mag, t_mag;

    always_comb
    begin
        if (half_precision)
        begin
            v_mag = {16'd0, element_bits[14:0]};
            t_mag = {16'd0, threshold_bits[14:0]};
            v_neg = element_bits[15];
            t_neg = threshold_bits[15];
            v_nan = (element_bits[14:10] == 5'h1f) && (element_bits[9:0] != '0);
            t_nan = (threshold_bits[14:10] == 5'h1f) && (threshold_bits[9:0] != '0);
        end
        else
        begin
            v_mag = element_bits[30:0];
            t_mag = threshold_bits[30:0];
            v_neg = element_bits[31];
            t_neg = threshold_bits[31];
            v_nan = (element_bits[30:23] == 8'hff) && (element_bits[22:0] != '0);
            t_nan = (threshold_bits[30:23] == 8'hff) && (threshold_bits[22:0] != '0);
        end
        v_zero = (v_mag == '0);
        t_zero = (t_mag == '0);
        // rv >= rt || rv <= -rt  <=>  |v| >= |t| when t >= 0; always when t < 0
        if (v_nan || t_nan)
            keep = 1'b0;
        else if (t_neg && !t_zero)
            keep = 1'b1;
        else
            keep = (v_mag >= t_mag) || v_zero && t_zero;
    end

endmodule

### rtl/core/d2csr_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d2csr_serializer: result queue
// Holds one slot of up to three results and drains it one per cycle while m_axis_tready is high.
// ----------------------------------------------------------------------------
module d2csr_serializer
    import d2csr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  slot_t                  slot,
    output logic                   empty_next_ok,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OutDataW-1:0]    m_axis_tdata,
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast
);
    slot_t      slot_reg;
    logic [2:0] pend_reg, pend_next;
    logic [2:0] cur;
    logic       pop;

    assign pop = m_axis_tvalid && m_axis_tready;
    // lowest pending result is sent first
    assign cur = pend_reg & ~(pend_reg - 3'd1);
    assign m_axis_tvalid = (pend_reg != '0);
    // can accept a new slot when empty or when the last pending result is leaving
    assign empty_next_ok = (pend_reg == '0) || (pop && (pend_reg == cur));

    always_comb
    begin
        pend_next = pend_reg;
        if (pop)
            pend_next = pend_reg & ~cur;
        if (load)
            pend_next = {slot.end_ptr, slot.entry, slot.first_ptr};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            slot_reg <= slot;
    end

    always_comb
    begin
        m_axis_tuser = KIND_PTR;
        m_axis_tlast = 1'b0;
        m_axis_tdata = '0;
        if (cur[1])
        begin
            m_axis_tuser = KIND_ENTRY;
            m_axis_tdata = {{(PtrW+3){1'b0}}, slot_reg.value, slot_reg.column};
        end
        else if (cur[2])
        begin
            m_axis_tlast = slot_reg.last;
            m_axis_tdata = {3'd0, slot_reg.ptr, {(ValW+ColW){1'b0}}};
        end
    end

endmodule
